// ----- hw/rtl/mbrc_pkg.sv -----
// Shared types, codes and CRC helper for the Modbus RTU response checker.
package mbrc_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [7:0] FN_READ_HOLDING = 8'h03;
  localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;
  localparam logic [7:0] FN_WRITE_MULTI  = 8'h10;
  localparam logic [7:0] FN_EXCEPTION_FLAG = 8'h80;

  localparam logic [15:0] MAX_READ_REGS  = 16'd125;
  localparam logic [15:0] MAX_WRITE_REGS = 16'd123;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_SLAVE       = 4'd1;
  localparam logic [3:0] ST_FUNCTION    = 4'd2;
  localparam logic [3:0] ST_EXCEPTION   = 4'd3;
  localparam logic [3:0] ST_EXC_CRC     = 4'd4;
  localparam logic [3:0] ST_CRC         = 4'd5;
  localparam logic [3:0] ST_BYTE_COUNT  = 4'd6;
  localparam logic [3:0] ST_ECHO        = 4'd7;
  localparam logic [3:0] ST_TIMEOUT     = 4'd8;
  localparam logic [3:0] ST_COUNT       = 4'd9;
  localparam logic [3:0] ST_UNSUPPORTED = 4'd10;

  localparam logic KIND_WORD   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  slave_id;
    logic [7:0]  function_code;
    logic [15:0] reg_address;
    logic [15:0] count_or_value;
    logic [7:0]  rx_byte;
  } req_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] reg_word;
    logic [6:0]  reg_index;
    logic [3:0]  status;
    logic [7:0]  exception_code;
    logic        last;
  } res_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/mbrc_in_reg.sv -----
// Input register stage: holds one accepted request item until it is processed.
module mbrc_in_reg
  import mbrc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t req_d,
  input  logic out_hold,
  output logic step,
  output req_t req_q
);

  logic q_valid;

  assign step     = q_valid && !out_hold;
  assign in_ready = !q_valid || !out_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_q <= req_d;
    end
  end

endmodule

// ----- hw/rtl/mbrc_core.sv -----
// Transaction state, CRC and frame checks; one item per step.
module mbrc_core
  import mbrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        step,
  input  req_t        req,
  output logic        res_valid,
  output res_t        res
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_EXCEPTION,
    PH_BODY
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] timeout_ticks;
  logic [7:0]  byte_position, byte_position_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  expected_slave, expected_slave_next;
  logic [7:0]  expected_function, expected_function_next;
  logic [15:0] expected_address, expected_address_next;
  logic [15:0] expected_value, expected_value_next;
  logic [7:0]  expected_length, expected_length_next;
  logic [7:0]  byte_count_seen, byte_count_seen_next;
  logic [7:0]  pending_high_byte, pending_high_byte_next;
  logic        echo_matches, echo_matches_next;
  logic [15:0] tick_counter, tick_counter_next;

  logic [7:0]  b;
  logic [7:0]  pos;
  logic [15:0] crc_new;
  logic [8:0]  pos_p1;
  logic [8:0]  pos_p2;
  logic [16:0] tick_p1;
  logic [7:0]  word_off;
  logic [7:0]  want;
  logic        fn_ok;
  logic        count_bad;

  assign b        = req.rx_byte;
  assign pos      = byte_position;
  assign crc_new  = crc_feed(running_crc, b);
  assign pos_p1   = {1'b0, pos} + 9'd1;
  assign pos_p2   = {1'b0, pos} + 9'd2;
  assign tick_p1  = {1'b0, tick_counter} + 17'd1;
  assign word_off = pos - 8'd4;

  assign fn_ok = (req.function_code == FN_READ_HOLDING) ||
                 (req.function_code == FN_WRITE_SINGLE) ||
                 (req.function_code == FN_WRITE_MULTI);
  assign count_bad =
    ((req.function_code == FN_READ_HOLDING) &&
     (req.count_or_value == 16'd0 || req.count_or_value > MAX_READ_REGS)) ||
    ((req.function_code == FN_WRITE_MULTI) &&
     (req.count_or_value == 16'd0 || req.count_or_value > MAX_WRITE_REGS));

  always_comb begin
    unique case (pos)
      8'd2:    want = expected_address[15:8];
      8'd3:    want = expected_address[7:0];
      8'd4:    want = expected_value[15:8];
      default: want = expected_value[7:0];
    endcase
  end

  always_comb begin
    phase_next             = phase;
    byte_position_next     = byte_position;
    running_crc_next       = running_crc;
    expected_slave_next    = expected_slave;
    expected_function_next = expected_function;
    expected_address_next  = expected_address;
    expected_value_next    = expected_value;
    expected_length_next   = expected_length;
    byte_count_seen_next   = byte_count_seen;
    pending_high_byte_next = pending_high_byte;
    echo_matches_next      = echo_matches;
    tick_counter_next      = tick_counter;
    res_valid              = 1'b0;
    res                    = '0;
    res.result_kind        = KIND_STATUS;

    if (step) begin
      unique case (req.op)
        OP_START: begin
          phase_next = PH_IDLE;
          if (!fn_ok) begin
            res_valid = 1'b1;
            res.status = ST_UNSUPPORTED;
          end else if (count_bad) begin
            res_valid = 1'b1;
            res.status = ST_COUNT;
          end else begin
            expected_slave_next    = req.slave_id;
            expected_function_next = req.function_code;
            expected_address_next  = req.reg_address;
            expected_value_next    = req.count_or_value;
            expected_length_next   = (req.function_code == FN_READ_HOLDING) ?
                                     8'd5 + {req.count_or_value[6:0], 1'b0} : 8'd8;
            byte_position_next     = 8'd0;
            running_crc_next       = CRC_INIT;
            byte_count_seen_next   = 8'd0;
            pending_high_byte_next = 8'd0;
            echo_matches_next      = 1'b1;
            tick_counter_next      = 16'd0;
            phase_next             = PH_HEADER;
          end
        end
        OP_BYTE: begin
          if (phase != PH_IDLE) begin
            running_crc_next   = crc_new;
            byte_position_next = pos_p1[7:0];
            unique case (phase)
              PH_HEADER: begin
                if (pos == 8'd0) begin
                  if (b != expected_slave) begin
                    res_valid  = 1'b1;
                    res.status = ST_SLAVE;
                  end
                end else if (b == (expected_function | FN_EXCEPTION_FLAG)) begin
                  phase_next = PH_EXCEPTION;
                end else if (b != expected_function) begin
                  res_valid  = 1'b1;
                  res.status = ST_FUNCTION;
                end else begin
                  phase_next = PH_BODY;
                end
              end
              PH_EXCEPTION: begin
                if (pos == 8'd2) begin
                  pending_high_byte_next = b;
                end
                if (pos >= 8'd4) begin
                  res_valid = 1'b1;
                  if (crc_new == 16'd0) begin
                    res.status         = ST_EXCEPTION;
                    res.exception_code = pending_high_byte;
                  end else begin
                    res.status = ST_EXC_CRC;
                  end
                end
              end
              PH_BODY: begin
                if (pos_p1 >= {1'b0, expected_length}) begin
                  res_valid = 1'b1;
                  if (crc_new != 16'd0) begin
                    res.status = ST_CRC;
                  end else if (expected_function == FN_READ_HOLDING &&
                               byte_count_seen != {expected_value[6:0], 1'b0}) begin
                    res.status = ST_BYTE_COUNT;
                  end else if (expected_function == FN_WRITE_SINGLE && !echo_matches) begin
                    res.status = ST_ECHO;
                  end else begin
                    res.status = ST_OK;
                  end
                end else if (pos_p2 >= {1'b0, expected_length}) begin
                  // CRC low byte
                end else if (expected_function == FN_READ_HOLDING) begin
                  if (pos == 8'd2) begin
                    byte_count_seen_next = b;
                  end else if (pos[0]) begin
                    pending_high_byte_next = b;
                  end else begin
                    res_valid       = 1'b1;
                    res.result_kind = KIND_WORD;
                    res.reg_word    = {pending_high_byte, b};
                    res.reg_index   = word_off[7:1];
                  end
                end else if (expected_function == FN_WRITE_SINGLE) begin
                  if (b != want) begin
                    echo_matches_next = 1'b0;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        OP_TICK: begin
          if (phase != PH_IDLE) begin
            if (tick_p1 >= {1'b0, timeout_ticks}) begin
              tick_counter_next = 16'd0;
              res_valid         = 1'b1;
              res.status        = ST_TIMEOUT;
            end else begin
              tick_counter_next = tick_p1[15:0];
            end
          end
        end
        default: begin
        end
      endcase

      if (res_valid && res.result_kind == KIND_STATUS) begin
        phase_next = PH_IDLE;
      end
    end

    if (res_valid) begin
      res.last = res.result_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      timeout_ticks     <= TIMEOUT_RESET;
      byte_position     <= 8'd0;
      running_crc       <= CRC_INIT;
      expected_slave    <= 8'd0;
      expected_function <= 8'd0;
      expected_address  <= 16'd0;
      expected_value    <= 16'd0;
      expected_length   <= 8'd0;
      byte_count_seen   <= 8'd0;
      pending_high_byte <= 8'd0;
      echo_matches      <= 1'b1;
      tick_counter      <= 16'd0;
    end else begin
      phase             <= phase_next;
      byte_position     <= byte_position_next;
      running_crc       <= running_crc_next;
      expected_slave    <= expected_slave_next;
      expected_function <= expected_function_next;
      expected_address  <= expected_address_next;
      expected_value    <= expected_value_next;
      expected_length   <= expected_length_next;
      byte_count_seen   <= byte_count_seen_next;
      pending_high_byte <= pending_high_byte_next;
      echo_matches      <= echo_matches_next;
      tick_counter      <= tick_counter_next;
      if (cfg_write) begin
        timeout_ticks <= cfg_data;
      end
    end
  end

endmodule

// ----- hw/rtl/mbrc_out_reg.sv -----
// Result register: holds one result until the receiver takes the transfer.
module mbrc_out_reg
  import mbrc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  res_t res_d,
  input  logic out_ready,
  output logic out_valid,
  output logic out_hold,
  output res_t res_q
);

  assign out_hold = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load || out_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_d;
    end
  end

endmodule

// ----- hw/rtl/modbus_rtu_master_response_check.sv -----
// Top level of the Modbus RTU master response checker.
//
// Input channel (in_valid/in_ready): one transfer per item; op selects start of a
// transaction (request fields), a received response byte (rx_byte) or a timer tick.
// Output channel (out_valid/out_ready): register words (result_kind 0) as each low
// byte arrives, then one final status with last set. Items that cause no result
// produce no transfer.
// Configuration: cfg_write with cfg_data loads timeout_ticks; write only while idle.
// Path: an accepted item is held in the input register, and the result register is loaded
// from the core when that item steps, which a receiver stall can hold off.
// Throughput: one item per cycle while the receiver does not stall; the byte-wise CRC
// update and frame checks sit combinationally between the two registers.
// Reset (rst, synchronous): checker idle, timeout_ticks 1000, no result pending.
// Receiver stall: the result register holds; while it does, an item in the input
// register waits there and in_ready drops, so at most one item waits inside the block.
module modbus_rtu_master_response_check
  import mbrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [7:0]  slave_id,
  input  logic [7:0]  function_code,
  input  logic [15:0] reg_address,
  input  logic [15:0] count_or_value,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [15:0] reg_word,
  output logic [6:0]  reg_index,
  output logic [3:0]  status,
  output logic [7:0]  exception_code,
  output logic        last
);

  req_t req_d, req_q;
  res_t res_d, res_q;
  logic step;
  logic out_hold;
  logic res_valid;

  assign req_d.op             = op;
  assign req_d.slave_id       = slave_id;
  assign req_d.function_code  = function_code;
  assign req_d.reg_address    = reg_address;
  assign req_d.count_or_value = count_or_value;
  assign req_d.rx_byte        = rx_byte;

  mbrc_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_d    (req_d),
    .out_hold (out_hold),
    .step     (step),
    .req_q    (req_q)
  );

  mbrc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .step      (step),
    .req       (req_q),
    .res_valid (res_valid),
    .res       (res_d)
  );

  mbrc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res_d     (res_d),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_hold  (out_hold),
    .res_q     (res_q)
  );

  assign result_kind    = res_q.result_kind;
  assign reg_word       = res_q.reg_word;
  assign reg_index      = res_q.reg_index;
  assign status         = res_q.status;
  assign exception_code = res_q.exception_code;
  assign last           = res_q.last;

endmodule
